[rtl/core/rld_pkg.sv]
// Shared types, constants and helpers for the route loop detector.
package rld_pkg;

    // Default number of stored hops per route
    localparam int MAX_HOPS_DEF = 32;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int FIELD5_W  = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [FIELD5_W-1:0] FIELD5_MAX = 5'd31;

    // Route summary handed from the load engine to the result sequencer
    typedef struct packed {
        logic                done;
        logic                overflow;
        logic [FIELD5_W-1:0] cycle_count;
        logic [FIELD5_W-1:0] longest;
    } route_status_t;

    // Clamp a distance to the 5-bit result field
    function automatic logic [FIELD5_W-1:0] sat5(input logic [31:0] v);
        logic [FIELD5_W-1:0] r;
        if (v > 32'(FIELD5_MAX)) begin
            r = FIELD5_MAX;
        end else begin
            r = v[FIELD5_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/rld_scan.sv]
// Hop load engine: stores hop addresses and scans earlier hops for repeats.
module rld_scan import rld_pkg::*; #(
    parameter int MAX_HOPS = MAX_HOPS_DEF,
    localparam int IDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1,
    localparam int CNT_W = $clog2(MAX_HOPS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADDR_W-1:0]   in_addr,
    input  logic                in_last,
    input  logic                route_clear,
    input  logic [IDX_W-1:0]    rd_idx,
    output logic                rd_mark,
    output logic [CNT_W-1:0]    hop_count,
    output route_status_t       status
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_HOLD} scan_state_t;

    scan_state_t          state_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 last_reg;
    logic [IDX_W-1:0]     issue_idx_reg;
    logic                 issue_done_reg;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [1:0]           match_cnt_reg;
    logic [IDX_W-1:0]     first_idx_reg;
    logic [CNT_W-1:0]     hop_count_reg;
    logic                 overflow_reg;
    logic [FIELD5_W-1:0]  cyc_cnt_reg;
    logic [FIELD5_W-1:0]  longest_reg;
    logic [MAX_HOPS-1:0]  cycle_bits_reg;

    // Hop address store, one read and one write port
    logic [ADDR_W-1:0]    hop_mem [MAX_HOPS];
    logic [ADDR_W-1:0]    rd_data_reg;

    logic                 full;
    logic                 fast_store;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_data;
    logic [IDX_W-1:0]     wr_idx;
    logic                 hit;
    logic                 last_cmp;
    logic [CNT_W-1:0]     hop_gap;
    logic [FIELD5_W-1:0]  gap_sat;

    assign full       = (hop_count_reg == CNT_W'(MAX_HOPS));
    // Zero address or first hop needs no scan
    assign fast_store = (state_reg == S_IDLE) && in_valid && !full &&
                        ((in_addr == '0) || (hop_count_reg == '0));
    assign wr_en      = fast_store || (state_reg == S_FIN);
    assign wr_data    = (state_reg == S_FIN) ? addr_reg : in_addr;
    assign wr_idx     = hop_count_reg[IDX_W-1:0];

    assign hit      = cmp_vld_reg && (rd_data_reg == addr_reg);
    assign last_cmp = cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == hop_count_reg);
    assign hop_gap  = hop_count_reg - CNT_W'(first_idx_reg);
    assign gap_sat  = sat5(32'(hop_gap));

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hop_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= hop_mem[issue_idx_reg];
    end

    // Load and scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_idx_reg  <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            match_cnt_reg  <= '0;
            first_idx_reg  <= '0;
            hop_count_reg  <= '0;
            overflow_reg   <= 1'b0;
            cyc_cnt_reg    <= '0;
            longest_reg    <= '0;
            cycle_bits_reg <= '0;
            last_reg       <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        last_reg <= in_last;
                        addr_reg <= in_addr;
                        if (full) begin
                            overflow_reg <= 1'b1;
                            if (in_last) begin
                                state_reg <= S_HOLD;
                            end
                        end else if (fast_store) begin
                            hop_count_reg <= hop_count_reg + CNT_W'(1);
                            if (in_last) begin
                                state_reg <= S_HOLD;
                            end
                        end else begin
                            issue_idx_reg  <= '0;
                            issue_done_reg <= 1'b0;
                            cmp_vld_reg    <= 1'b0;
                            match_cnt_reg  <= '0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one read a cycle over the stored hops
                    if (!issue_done_reg) begin
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= issue_idx_reg;
                        if ((CNT_W'(issue_idx_reg) + CNT_W'(1)) == hop_count_reg) begin
                            issue_done_reg <= 1'b1;
                        end else begin
                            issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                        end
                    end else begin
                        cmp_vld_reg <= 1'b0;
                    end
                    // Compare returning data, keep first match position
                    if (hit) begin
                        if (match_cnt_reg == 2'd0) begin
                            first_idx_reg <= cmp_idx_reg;
                        end
                        if (match_cnt_reg != 2'd2) begin
                            match_cnt_reg <= match_cnt_reg + 2'd1;
                        end
                    end
                    if (last_cmp) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Store mark; second occurrence counts a new repeated address
                    cycle_bits_reg[wr_idx] <= (match_cnt_reg != 2'd0);
                    hop_count_reg          <= hop_count_reg + CNT_W'(1);
                    if ((match_cnt_reg == 2'd1) && (cyc_cnt_reg != FIELD5_MAX)) begin
                        cyc_cnt_reg <= cyc_cnt_reg + FIELD5_W'(1);
                    end
                    if ((match_cnt_reg != 2'd0) && (gap_sat > longest_reg)) begin
                        longest_reg <= gap_sat;
                    end
                    state_reg <= last_reg ? S_HOLD : S_IDLE;
                end
                S_HOLD: begin
                    // Route complete; clear once all results went out
                    if (route_clear) begin
                        hop_count_reg  <= '0;
                        overflow_reg   <= 1'b0;
                        cyc_cnt_reg    <= '0;
                        longest_reg    <= '0;
                        cycle_bits_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign rd_mark            = cycle_bits_reg[rd_idx];
    assign hop_count          = hop_count_reg;
    assign status.done        = (state_reg == S_HOLD);
    assign status.overflow    = overflow_reg;
    assign status.cycle_count = cyc_cnt_reg;
    assign status.longest     = longest_reg;

endmodule

[rtl/core/route_loop_detector.sv]
// Route loop detector: loads a route's hops, flags repeats, reports per-hop results.
// Load: a zero address or the first hop is stored without a scan; any other hop
//   scans the stored hops, one stored hop read per cycle from the hop memory.
// Results: once the last hop is stored, each result is registered in E_LOAD and held in
//   E_SEND until m_tready is high; no input is taken during reporting.
// Reset (aresetn low, synchronous) clears the route state; the hop memory is not cleared.
module route_loop_detector import rld_pkg::*; #(
    parameter int MAX_HOPS = MAX_HOPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] hop_address
    input  logic                 s_tlast,   // last_hop
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [4:0] hop_index, [5] cycle_mark, [10:6] cycle_count, [15:11] longest_cycle,
    // [16] truncated, [23:17] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast    // final_result
);

    localparam int IDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int CNT_W = $clog2(MAX_HOPS + 1);

    typedef enum logic [1:0] {E_WAIT, E_LOAD, E_SEND} emit_state_t;

    emit_state_t          state_reg;
    logic [CNT_W-1:0]     out_idx_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic                 route_clear;
    logic                 rd_mark;
    logic [CNT_W-1:0]     hop_count;
    route_status_t        status;
    logic                 is_final;

    rld_scan #(
        .MAX_HOPS (MAX_HOPS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_addr     (s_tdata[ADDR_W-1:0]),
        .in_last     (s_tlast),
        .route_clear (route_clear),
        .rd_idx      (out_idx_reg[IDX_W-1:0]),
        .rd_mark     (rd_mark),
        .hop_count   (hop_count),
        .status      (status)
    );

    assign is_final    = ((out_idx_reg + CNT_W'(1)) == hop_count);
    assign route_clear = (state_reg == E_SEND) && m_tready && m_tlast_reg;

    // Result sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= E_WAIT;
            out_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                E_WAIT: begin
                    if (status.done) begin
                        out_idx_reg <= '0;
                        state_reg   <= E_LOAD;
                    end
                end
                E_LOAD: begin
                    m_tvalid_reg <= 1'b1;
                    m_tlast_reg  <= is_final;
                    m_tdata_reg  <= {7'd0,
                                     status.overflow,
                                     is_final ? status.longest : '0,
                                     is_final ? status.cycle_count : '0,
                                     rd_mark,
                                     FIELD5_W'(out_idx_reg)};
                    state_reg    <= E_SEND;
                end
                E_SEND: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (m_tlast_reg) begin
                            state_reg <= E_WAIT;
                        end else begin
                            out_idx_reg <= out_idx_reg + CNT_W'(1);
                            state_reg   <= E_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= E_WAIT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    // No hop is taken while a result is on offer
    a_no_load_during_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while reporting");

    // Stored hop count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hop_count <= CNT_W'(MAX_HOPS))
        else $error("hop count beyond capacity");

    // Final result transaction clears the route
    a_clear_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (hop_count == '0))
        else $error("route not cleared after final result");

    // Reported index always refers to a stored hop
    a_index_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_idx_reg < hop_count))
        else $error("result index beyond stored hops");
`endif

endmodule

[dv/route_loop_detector_tb.sv]
// Self-checking testbench for route_loop_detector: routes in, per-hop cycle reports checked.
module route_loop_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rld_pkg::*;

    // One per-hop report as the block should produce it
    typedef struct {
        logic [FIELD5_W-1:0] hop_index;
        logic                cycle_mark;
        logic [FIELD5_W-1:0] cycle_count;
        logic [FIELD5_W-1:0] longest_cycle;
        logic                truncated;
        logic                final_result;
    } hop_report_t;

    // Tracks the route being loaded and queues the reports it must yield
    class route_tracker;
        logic [ADDR_W-1:0] hop_mem [MAX_HOPS_DEF];
        bit                repeat_flag [MAX_HOPS_DEF];
        int                stored_hops;
        bit                hop_dropped;
        hop_report_t       expected_reports[$];
        int                mismatch_count;

        task report_mismatch(string msg);
            mismatch_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function int pending();
            return expected_reports.size();
        endfunction

        // Apply one accepted hop; a last hop closes the route and queues its reports
        function void note_hop(logic [ADDR_W-1:0] addr, logic last);
            bit          mark;
            bit          later;
            int          repeats;
            int          longest;
            hop_report_t r;
            if (stored_hops < MAX_HOPS_DEF) begin
                mark = 0;
                if (addr != '0) begin
                    for (int j = 0; j < stored_hops; j++) begin
                        if (hop_mem[j] == addr) mark = 1;
                    end
                end
                hop_mem[stored_hops]     = addr;
                repeat_flag[stored_hops] = mark;
                stored_hops++;
            end else begin
                hop_dropped = 1;
            end
            if (!last) return;

            // each repeated address counts once, at its last occurrence
            repeats = 0;
            longest = 0;
            for (int i = 0; i < stored_hops; i++) begin
                if (!repeat_flag[i]) continue;
                later = 0;
                for (int j = i + 1; j < stored_hops; j++) begin
                    if (hop_mem[j] == hop_mem[i]) later = 1;
                end
                if (later) continue;
                repeats++;
                for (int j = 0; j < i; j++) begin
                    if (hop_mem[j] == hop_mem[i]) begin
                        if (i - j > longest) longest = i - j;
                        break;
                    end
                end
            end
            if (repeats > 31) repeats = 31;
            if (longest > 31) longest = 31;

            for (int i = 0; i < stored_hops; i++) begin
                r.final_result  = (i + 1 == stored_hops);
                r.hop_index     = FIELD5_W'(i);
                r.cycle_mark    = repeat_flag[i];
                r.cycle_count   = r.final_result ? FIELD5_W'(repeats) : '0;
                r.longest_cycle = r.final_result ? FIELD5_W'(longest) : '0;
                r.truncated     = hop_dropped;
                expected_reports.insert(expected_reports.size(), r);
            end

            foreach (repeat_flag[k]) repeat_flag[k] = 0;
            stored_hops = 0;
            hop_dropped = 0;
        endfunction

        // Compare one accepted result transaction with the oldest expected report
        task check_report(logic [M_TDATA_W-1:0] data, logic last);
            hop_report_t e;
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b", data, last));
                return;
            end
            e = expected_reports[0];
            expected_reports.delete(0);
            if (data[4:0] !== e.hop_index)
                report_mismatch($sformatf("hop_index got %0d exp %0d", data[4:0], e.hop_index));
            if (data[5] !== e.cycle_mark)
                report_mismatch($sformatf("hop %0d cycle_mark got %b exp %b",
                                          e.hop_index, data[5], e.cycle_mark));
            if (data[10:6] !== e.cycle_count)
                report_mismatch($sformatf("hop %0d cycle_count got %0d exp %0d",
                                          e.hop_index, data[10:6], e.cycle_count));
            if (data[15:11] !== e.longest_cycle)
                report_mismatch($sformatf("hop %0d longest_cycle got %0d exp %0d",
                                          e.hop_index, data[15:11], e.longest_cycle));
            if (data[16] !== e.truncated)
                report_mismatch($sformatf("hop %0d truncated got %b exp %b",
                                          e.hop_index, data[16], e.truncated));
            if (data[M_TDATA_W-1:17] !== '0)
                report_mismatch($sformatf("hop %0d pad bits nonzero: %h",
                                          e.hop_index, data[M_TDATA_W-1:17]));
            if (last !== e.final_result)
                report_mismatch($sformatf("hop %0d final_result got %b exp %b",
                                          e.hop_index, last, e.final_result));
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    route_tracker tracker = new();

    int                src_idle_pct;
    int                sink_stall_pct;
    int                hops_sent;
    logic [ADDR_W-1:0] addr_pool [8];
    int                pool_size;

    route_loop_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure, updated on the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Result transactions are checked at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_report(m_tdata, m_tlast);
        end
    end

    // Drive one hop transaction, with optional idle cycles in front
    task automatic send_hop(input logic [ADDR_W-1:0] addr, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_hop(addr, last);
        hops_sent++;
        @(negedge aclk);
    endtask

    // Mostly addresses from a small pool so repeats are common
    function automatic logic [ADDR_W-1:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return '0;
        if (roll < 80) return addr_pool[$urandom_range(0, pool_size - 1)];
        return $urandom;
    endfunction

    // One random route; long ones may overrun the hop store, some close a full-length loop
    task automatic send_random_route(input bit force_long);
        int                len;
        bit                long_route;
        bit                close_loop;
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] addr;
        pool_size = $urandom_range(1, 6);
        for (int k = 0; k < pool_size; k++) begin
            addr_pool[k] = $urandom;
            if (addr_pool[k] == '0) addr_pool[k] = 32'h1;
        end
        long_route = force_long || ($urandom_range(0, 5) == 0);
        len        = long_route ? $urandom_range(30, 40) : $urandom_range(1, 12);
        close_loop = long_route && $urandom_range(0, 1);
        first_addr = '0;
        for (int i = 0; i < len; i++) begin
            addr = pick_address();
            if (close_loop && i == 0) addr = addr_pool[0];
            if (i == 0) first_addr = addr;
            if (close_loop && i == MAX_HOPS_DEF - 1) addr = first_addr;
            send_hop(addr, i == len - 1);
        end
    endtask

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int phase_start;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hops_sent      = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-hop routes at the address extremes
        send_hop(32'hFFFF_FFFF, 1'b1);
        send_hop(32'h0000_0000, 1'b1);
        // no-reply hops never form a cycle
        send_hop(32'h0, 1'b0);
        send_hop(32'h0, 1'b0);
        send_hop(32'h0, 1'b1);
        // two repeated addresses, one repeated twice, with a gap hop
        send_hop(32'h0A00_0001, 1'b0);
        send_hop(32'h0A00_0002, 1'b0);
        send_hop(32'h0A00_0001, 1'b0);
        send_hop(32'h0, 1'b0);
        send_hop(32'h0A00_0002, 1'b0);
        send_hop(32'h0A00_0001, 1'b0);
        send_hop(32'hC0A8_0101, 1'b1);
        // single-bit addresses, repeat on the final hop
        send_hop(32'h0000_0001, 1'b0);
        send_hop(32'h8000_0000, 1'b0);
        send_hop(32'h0000_0001, 1'b1);

        // random phases: no idling, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 17; sink_stall_pct = 17; end
            endcase
            phase_start = hops_sent;
            send_random_route(1'b1);
            while (hops_sent - phase_start < 45) send_random_route(1'b0);
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (tracker.mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
